// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define STPM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define STPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stpm_pkg.sv =====
// Types, constants, coefficients and helper functions of the true-peak meter.
package stpm_pkg;

  localparam int TAP_COUNT   = 8;
  localparam int PHASE_COUNT = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int LOOKAHEAD   = TAP_COUNT / 2;
  localparam int COEF_SHIFT  = 17;
  localparam int COEF_W      = COEF_SHIFT + 2;
  localparam int ACC_W       = SAMPLE_BITS + COEF_W;
  localparam int PEAK_W      = 26;
  localparam int FILL_W      = $clog2(LOOKAHEAD + 1);
  localparam int TAIL_W      = $clog2(LOOKAHEAD);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [PEAK_W-1:0]             peak_t;
  typedef logic [FILL_W-1:0]             fill_t;
  typedef logic [TAIL_W-1:0]             tail_t;

  localparam peak_t PEAK_MAX  = '1;
  localparam fill_t FILL_FULL = FILL_W'(LOOKAHEAD);
  localparam tail_t TAIL_LAST = TAIL_W'(LOOKAHEAD - 1);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_SHIFT - 1);

  // Hann-windowed sinc phases, unity DC gain, Q1.17
  localparam coef_t COEF [PHASE_COUNT][TAP_COUNT] = '{
    '{ 19'sd0,    19'sd0,    19'sd0,      19'sd131072,
       19'sd0,    19'sd0,    19'sd0,      19'sd0 },
    '{ -19'sd348, 19'sd4077, -19'sd16439, 19'sd114367,
       19'sd38122, -19'sd11742, 19'sd3336, -19'sd302 },
    '{ -19'sd452, 19'sd5135, -19'sd19171, 19'sd80024,
       19'sd80024, -19'sd19171, 19'sd5135, -19'sd452 },
    '{ -19'sd302, 19'sd3336, -19'sd11742, 19'sd38122,
       19'sd114367, -19'sd16439, 19'sd4077, -19'sd348 }
  };

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
    logic    last;
  } in_t;

  typedef struct packed {
    peak_t peak_magnitude;
    logic  silent;
  } out_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_TAIL = 2'b10
  } seq_state_t;

  // |acc| rounded half up to Q.23, saturated to the peak width
  function automatic peak_t round_mag(input acc_t acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rnd;
    mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
    rnd = (mag + RND_HALF) >> COEF_SHIFT;
    if (rnd > {{(ACC_W-PEAK_W){1'b0}}, PEAK_MAX}) begin
      return PEAK_MAX;
    end
    return rnd[PEAK_W-1:0];
  endfunction

endpackage

// ===== design/stereo_true_peak_meter.sv =====
// Stereo 4x-oversampled true-peak meter, top level.
// Throughput: one sample pair per cycle; a pair flagged last holds the input while
//   the four zero-padded tail positions enter the filter, and a last pair waits while a result is pending.
// The result is valid after the last pair is accepted once the four tail pushes,
//   then products, sums, magnitudes and the peak register have passed.
// Reset (rst, synchronous): clears histories, fill count, running peak and all valid flags.
`include "assert_macros.svh"

module stereo_true_peak_meter (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_stall,
  input  stpm_pkg::in_t  sample,
  output logic           peak_valid,
  input  logic           peak_stall,
  output stpm_pkg::out_t peak
);
  import stpm_pkg::*;

  seq_state_t state;
  tail_t      tail_cnt;
  fill_t      fill;
  peak_t      running_peak;
  peak_t      cand;

  logic accept, tail, push, close_pend;
  logic p0_v, p1_v, p2_v, p3_v;
  logic p0_c, p1_c, p2_c, p3_c;

  sample_t din_l, din_r;
  peak_t   mag_l [PHASE_COUNT];
  peak_t   mag_r [PHASE_COUNT];

  assign tail       = (state == ST_TAIL);
  assign close_pend = p0_c | p1_c | p2_c | p3_c;
  // a last transaction waits until any pending result has been taken by the receiver
  assign sample_stall = tail || (sample.last && (peak_valid || close_pend));
  assign accept     = sample_valid && !sample_stall;
  assign push       = accept || tail;
  assign din_l      = tail ? '0 : sample.left_sample;
  assign din_r      = tail ? '0 : sample.right_sample;

  stpm_chan u_left (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (din_l),
    .mag  (mag_l)
  );

  stpm_chan u_right (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (din_r),
    .mag  (mag_r)
  );

  always_comb begin
    cand = running_peak;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (mag_l[p] > cand) begin
        cand = mag_l[p];
      end
      if (mag_r[p] > cand) begin
        cand = mag_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      tail_cnt     <= '0;
      fill         <= '0;
      p0_v         <= 1'b0;
      p1_v         <= 1'b0;
      p2_v         <= 1'b0;
      p3_v         <= 1'b0;
      p0_c         <= 1'b0;
      p1_c         <= 1'b0;
      p2_c         <= 1'b0;
      p3_c         <= 1'b0;
      running_peak <= '0;
      peak_valid   <= 1'b0;
    end else begin
      // a position is scanned once four later samples (real or padding) exist
      p0_v <= push && (fill >= FILL_FULL);
      p0_c <= tail && (tail_cnt == TAIL_LAST);
      p1_v <= p0_v;
      p1_c <= p0_c;
      p2_v <= p1_v;
      p2_c <= p1_c;
      p3_v <= p2_v;
      p3_c <= p2_c;

      if (push && (fill < FILL_FULL)) begin
        fill <= fill + 1'b1;
      end

      case (state)
        ST_RUN: begin
          if (accept && sample.last) begin
            state    <= ST_TAIL;
            tail_cnt <= '0;
          end
        end
        ST_TAIL: begin
          tail_cnt <= tail_cnt + 1'b1;
          if (tail_cnt == TAIL_LAST) begin
            state <= ST_RUN;
            fill  <= '0;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase

      if (peak_valid && !peak_stall) begin
        peak_valid <= 1'b0;
      end
      if (p3_c) begin
        peak_valid   <= 1'b1;
        running_peak <= '0;
      end else if (p3_v) begin
        running_peak <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p3_c) begin
      peak.peak_magnitude <= cand;
      peak.silent         <= (cand == '0);
    end
  end

  `STPM_ASSERT(a_no_overwrite, !(peak_valid && peak_stall && p3_c), "result arrived while output held")
  `STPM_ASSERT_NEXT(a_last_tail, accept && sample.last, state == ST_TAIL, "last transaction did not start the tail")
  `STPM_ASSERT_NEXT(a_peak_clear, p3_c, running_peak == '0, "running peak not cleared after result")

endmodule

// ===== design/stpm_chan.sv =====
// One channel: sample history and the four-phase interpolator, three register stages.
module stpm_chan (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stpm_pkg::sample_t din,
  output stpm_pkg::peak_t   mag [stpm_pkg::PHASE_COUNT]
);
  import stpm_pkg::*;

  sample_t hist [TAP_COUNT];
  acc_t    prod [PHASE_COUNT][TAP_COUNT];
  acc_t    acc  [PHASE_COUNT];
  acc_t    acc_next [PHASE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        hist[k] <= '0;
      end
    end else if (push) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[TAP_COUNT-1] <= din;
    end
  end

  // constant-coefficient products of the position centred in the history
  always_ff @(posedge clk) begin
    for (int p = 0; p < PHASE_COUNT; p++) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        prod[p][k] <= acc_t'(hist[k]) * acc_t'(COEF[p][k]);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PHASE_COUNT; p++) begin
      acc_next[p] = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        acc_next[p] = acc_next[p] + prod[p][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PHASE_COUNT; p++) begin
      acc[p] <= acc_next[p];
      mag[p] <= round_mag(acc[p]);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the stereo true-peak meter: directed rows, then random buffers.
`timescale 1ns / 100ps

module tb_top;
  import stpm_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  localparam sample_t S_MAX  = 24'sh7FFFFF;
  localparam sample_t S_MIN  = 24'sh800000;
  localparam sample_t S_ZERO = 24'sh000000;

  localparam longint MAG_CEIL = (longint'(1) << 26) - 1;

  // Q1.17 interpolator phases, phase 0 is the original sample
  localparam int INTERP_COEF [4][8] = '{
    '{    0,    0,      0, 131072,      0,      0,    0,    0 },
    '{ -348, 4077, -16439, 114367,  38122, -11742, 3336, -302 },
    '{ -452, 5135, -19171,  80024,  80024, -19171, 5135, -452 },
    '{ -302, 3336, -11742,  38122, 114367, -16439, 4077, -348 }
  };

  typedef sample_t window_t [8];

  typedef struct {
    in_t  item;
    bit   known;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  in_t  sample_item = '0;
  logic peak_valid;
  logic peak_stall = 1'b0;
  out_t peak_result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int random_sent = 0;
  int errors = 0;
  int cycles = 0;

  out_t      pending_peaks [$];
  stim_row_t directed_rows [$];

  // predictor state
  window_t left_taps;
  window_t right_taps;
  longint  peak_so_far;
  int      samples_seen;

  stereo_true_peak_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_item),
    .peak_valid   (peak_valid),
    .peak_stall   (peak_stall),
    .peak         (peak_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_peaks.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void clear_meter();
    for (int k = 0; k < 8; k++) begin
      left_taps[k]  = S_ZERO;
      right_taps[k] = S_ZERO;
    end
    peak_so_far  = 0;
    samples_seen = 0;
  endfunction

  function automatic void shift_in(ref window_t w, input sample_t x);
    for (int k = 0; k < 7; k++) begin
      w[k] = w[k + 1];
    end
    w[7] = x;
  endfunction

  // all four phases of the position centred in the window
  function automatic void scan_window(input window_t w);
    longint acc;
    longint mag;
    for (int p = 0; p < 4; p++) begin
      acc = 0;
      for (int k = 0; k < 8; k++) begin
        acc += longint'(w[k]) * longint'(INTERP_COEF[p][k]);
      end
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + 65536) >>> 17;
      if (mag > MAG_CEIL) begin
        mag = MAG_CEIL;
      end
      if (mag > peak_so_far) begin
        peak_so_far = mag;
      end
    end
  endfunction

  function automatic bit meter_step(input in_t item, output out_t res);
    int seen;
    seen = samples_seen;
    res  = '0;
    shift_in(left_taps, item.left_sample);
    shift_in(right_taps, item.right_sample);
    if (seen >= 4) begin
      scan_window(left_taps);
      scan_window(right_taps);
    end
    if (samples_seen < 4) begin
      samples_seen++;
    end
    if (!item.last) begin
      return 1'b0;
    end
    // zero-padded tail
    for (int t = 1; t <= 4; t++) begin
      shift_in(left_taps, S_ZERO);
      shift_in(right_taps, S_ZERO);
      if (seen + t >= 4) begin
        scan_window(left_taps);
        scan_window(right_taps);
      end
    end
    res.peak_magnitude = peak_t'(peak_so_far);
    res.silent         = (peak_so_far == 0);
    clear_meter();
    return 1'b1;
  endfunction

  task automatic send_item(input in_t item, input bit known, input out_t want);
    out_t predicted;
    bit   has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= item;
    do @(posedge clk); while (sample_stall);
    has_res = meter_step(item, predicted);
    if (has_res) begin
      pending_peaks = {pending_peaks, (known ? want : predicted)};
    end
  endtask

  // hold the input until every outstanding result has come back
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_peaks.size() != 0);
  endtask

  task automatic add_row(input sample_t l, input sample_t r, input bit last,
                         input bit known, input int pk, input bit sil);
    stim_row_t row;
    row.item.left_sample    = l;
    row.item.right_sample   = r;
    row.item.last           = last;
    row.known               = known;
    row.want.peak_magnitude = peak_t'(pk);
    row.want.silent         = sil;
    directed_rows = {directed_rows, row};
  endtask

  function automatic sample_t draw_sample(input int style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($signed($urandom_range(6)) - 3);
      2: return S_ZERO;
      3: return $urandom_range(1) ? S_MAX : S_MIN;
      default: return ($urandom_range(3) == 0) ? S_ZERO : sample_t'($urandom);
    endcase
  endfunction

  task automatic run_buffer();
    in_t item;
    int  len;
    int  pick;
    int  style;
    pick  = $urandom_range(99);
    style = $urandom_range(4);
    if (pick < 30) begin
      len = $urandom_range(5, 1);
    end else if (pick < 90) begin
      len = $urandom_range(60, 6);
    end else begin
      len = $urandom_range(200, 61);
    end
    for (int i = 0; i < len; i++) begin
      item.left_sample  = draw_sample(style);
      item.right_sample = draw_sample(style);
      item.last         = (i == len - 1);
      send_item(item, 1'b0, '0);
      random_sent++;
    end
  endtask

  always @(posedge clk) begin
    peak_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && peak_valid && !peak_stall) begin
      if (pending_peaks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result: peak %0d silent %0d", peak_result.peak_magnitude,
                   peak_result.silent);
        end
      end else begin
        if (peak_result.peak_magnitude !== pending_peaks[0].peak_magnitude ||
            peak_result.silent !== pending_peaks[0].silent) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch: peak exp %0d got %0d, silent exp %0d got %0d",
                     pending_peaks[0].peak_magnitude, peak_result.peak_magnitude,
                     pending_peaks[0].silent, peak_result.silent);
          end
        end
        void'(pending_peaks.pop_front());
      end
    end
  end

  initial begin
    clear_meter();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single-sample buffers: the result is the sample magnitude, from phase 0
    add_row(S_ZERO, S_ZERO, 1'b1, 1'b1, 0, 1'b1);
    add_row(S_MAX, S_ZERO, 1'b1, 1'b1, 8388607, 1'b0);
    add_row(S_ZERO, S_MIN, 1'b1, 1'b1, 8388608, 1'b0);
    add_row(24'sd1, S_ZERO, 1'b1, 1'b1, 1, 1'b0);
    // short streams
    add_row(24'sd100, -24'sd100, 1'b0, 1'b0, 0, 1'b0);
    add_row(-24'sd5000, 24'sd7, 1'b1, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MIN, S_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b1, 1'b0, 0, 1'b0);
    // full-scale pattern matched to the half-sample phase signs
    add_row(S_MIN, S_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MIN, S_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MIN, S_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MAX, S_MIN, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_MIN, S_MAX, 1'b1, 1'b0, 0, 1'b0);
    // longer silent buffer
    add_row(S_ZERO, S_ZERO, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_ZERO, S_ZERO, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_ZERO, S_ZERO, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_ZERO, S_ZERO, 1'b0, 1'b0, 0, 1'b0);
    add_row(S_ZERO, S_ZERO, 1'b1, 1'b1, 0, 1'b1);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
    end
    drain_results();

    // idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      while (random_sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        run_buffer();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_peaks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/stpm_pkg.sv
design/stpm_chan.sv
design/stereo_true_peak_meter.sv
tb/tb_top.sv
